FILE: rtl/core/prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants for the preheat/read event scheduler.
// ----------------------------------------------------------------------------
package prs_pkg;

   localparam int NUM_SLOTS  = 8;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CMP_BITS   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // request commands
   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_DEFINE = 2'd1,
      CMD_START  = 2'd2,
      CMD_STOP   = 2'd3
   } cmd_type;

   // event phases
   localparam logic EV_WARMUP = 1'b0;
   localparam logic EV_SAMPLE = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_TICK_A,
      ST_TICK_B,
      ST_DEF_SCAN,
      ST_DEF_WRITE,
      ST_FLUSH
   } state_type;

   // one entry of the slot table
   typedef struct packed {
      logic [3:0]            client;
      logic [15:0]           interval;
      logic [15:0]           offset;
      logic                  prime;
      logic [COUNT_BITS-1:0] elapsed;
      logic                  done;
   } slot_type;

endpackage

FILE: rtl/core/prs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_req_if / prs_rsp_if
// Valid/ready channels for scheduler requests and emitted events.
// ----------------------------------------------------------------------------
interface prs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [2:0]  slot;
   logic [3:0]  client_id;
   logic [15:0] interval_seconds;
   logic [15:0] preheat_offset;
   logic        prime_on_start;

   modport source (output valid, cmd, slot, client_id, interval_seconds,
                   preheat_offset, prime_on_start, input ready);
   modport sink   (input valid, cmd, slot, client_id, interval_seconds,
                   preheat_offset, prime_on_start, output ready);
endinterface

interface prs_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] event_client;
   logic       event_phase;
   logic       last_event;

   modport source (output valid, event_client, event_phase, last_event, input ready);
   modport sink   (input valid, event_client, event_phase, last_event, output ready);
endinterface

FILE: rtl/core/preheat_read_event_scheduler.sv
`timescale 1ns / 1ps
// Tick: the slot table is walked one entry at a time, each split into a count/preheat step
// and a read step, then a flush step; a step whose event cannot be placed stalls the walk.
// Start: a prime step per slot, then flush; define: id scan up to the first match or the last
// slot, then write. Stop, and tick while stopped: nothing beyond the accept. One transaction in flight at a time.
// Reset (synchronous, active high) clears the slot table, the running flag and all valids.
// ----------------------------------------------------------------------------
// preheat_read_event_scheduler
// Periodic sensor slot table issuing preheat and read events, one slot per step.
// ----------------------------------------------------------------------------
module preheat_read_event_scheduler (
   input logic       clock,
   input logic       reset,
   prs_req_if.sink   req_ch,
   prs_rsp_if.source rsp_ch
);

   prs_pkg::state_type state_ff, state_in;
   logic [prs_pkg::IDX_BITS-1:0] idx_ff, idx_in;
   logic running_ff, running_in;
   prs_pkg::slot_type slot_ff [prs_pkg::NUM_SLOTS];

   // latched define payload
   logic [prs_pkg::IDX_BITS-1:0] tgt_ff, tgt_in;
   logic [3:0]  def_client_ff, def_client_in;
   logic [15:0] def_interval_ff, def_interval_in;
   logic [15:0] def_offset_ff, def_offset_in;
   logic        def_prime_ff, def_prime_in;
   logic        found_ff, found_in;
   logic [prs_pkg::COUNT_BITS-1:0] carry_el_ff, carry_el_in;
   logic        carry_done_ff, carry_done_in;

   // event held back until we know whether it is the last one
   logic       held_valid_ff, held_valid_in;
   logic [3:0] held_client_ff, held_client_in;
   logic       held_phase_ff, held_phase_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [3:0] out_client_ff, out_client_in;
   logic       out_phase_ff, out_phase_in;
   logic       out_last_ff, out_last_in;

   // datapath signals
   prs_pkg::slot_type cur;
   prs_pkg::slot_type wr_data;
   logic [prs_pkg::IDX_BITS-1:0] wr_idx;
   logic wr_en;
   logic [prs_pkg::COUNT_BITS-1:0] el_inc;
   logic [15:0] moment;
   logic active, last_idx, match, out_free, accept, slot_ok;
   logic emit_req, emit_phase, step_go, fire, out_load, out_last_sel;
   logic [3:0] emit_client;
   prs_pkg::cmd_type req_cmd;

   assign req_cmd = prs_pkg::cmd_type'(req_ch.cmd);
   assign accept  = req_ch.valid && req_ch.ready;
   assign slot_ok = 32'(req_ch.slot) < prs_pkg::NUM_SLOTS;

   // shared slot unit: one table entry per cycle, unless a step stalls
   always_comb begin
      cur      = slot_ff[idx_ff];
      el_inc   = (cur.elapsed == prs_pkg::COUNT_MAX) ? cur.elapsed
                                                    : cur.elapsed + prs_pkg::COUNT_BITS'(1);
      active   = (cur.client != 4'd0) && (cur.interval != 16'd0);
      moment   = (cur.interval > cur.offset) ? (cur.interval - cur.offset) : cur.interval;
      last_idx = (idx_ff == prs_pkg::IDX_BITS'(prs_pkg::NUM_SLOTS - 1));
      match    = (def_client_ff != 4'd0) && (cur.client == def_client_ff);
      out_free = !out_valid_ff || rsp_ch.ready;

      emit_req    = 1'b0;
      emit_client = cur.client;
      emit_phase  = prs_pkg::EV_WARMUP;
      wr_en       = 1'b0;
      wr_idx      = idx_ff;
      wr_data     = cur;

      idx_in          = idx_ff;
      running_in      = running_ff;
      tgt_in          = tgt_ff;
      def_client_in   = def_client_ff;
      def_interval_in = def_interval_ff;
      def_offset_in   = def_offset_ff;
      def_prime_in    = def_prime_ff;
      found_in        = found_ff;
      carry_el_in     = carry_el_ff;
      carry_done_in   = carry_done_ff;

      case (state_ff)
         prs_pkg::ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               case (req_cmd)
                  prs_pkg::CMD_DEFINE: begin
                     tgt_in          = prs_pkg::IDX_BITS'(req_ch.slot);
                     def_client_in   = req_ch.client_id;
                     def_interval_in = req_ch.interval_seconds;
                     def_offset_in   = req_ch.preheat_offset;
                     def_prime_in    = req_ch.prime_on_start;
                     found_in        = 1'b0;
                  end
                  prs_pkg::CMD_START: running_in = 1'b1;
                  prs_pkg::CMD_STOP:  running_in = 1'b0;
                  default: ;
               endcase
            end
         end
         prs_pkg::ST_START: begin
            if (cur.prime) begin
               emit_req        = 1'b1;
               wr_en           = 1'b1;
               wr_data.elapsed = '0;
               wr_data.done    = 1'b1;
            end
         end
         // count advance and preheat check
         prs_pkg::ST_TICK_A: begin
            wr_en           = 1'b1;
            wr_data.elapsed = el_inc;
            if (active && !cur.done && (cur.offset != 16'd0) &&
                (prs_pkg::CMP_BITS'(el_inc) == prs_pkg::CMP_BITS'(moment))) begin
               emit_req     = 1'b1;
               wr_data.done = 1'b1;
            end
         end
         // read check on the updated count
         prs_pkg::ST_TICK_B: begin
            if (active &&
                (prs_pkg::CMP_BITS'(cur.elapsed) >= prs_pkg::CMP_BITS'(cur.interval))) begin
               emit_req        = 1'b1;
               emit_phase      = prs_pkg::EV_SAMPLE;
               wr_en           = 1'b1;
               wr_data.elapsed = '0;
               wr_data.done    = 1'b0;
            end
         end
         // lowest slot with the same id donates count and mark
         prs_pkg::ST_DEF_SCAN: begin
            if (match) begin
               found_in      = 1'b1;
               carry_el_in   = cur.elapsed;
               carry_done_in = cur.done;
            end
         end
         prs_pkg::ST_DEF_WRITE: begin
            wr_en            = 1'b1;
            wr_idx           = tgt_ff;
            wr_data.client   = def_client_ff;
            wr_data.interval = def_interval_ff;
            wr_data.offset   = def_offset_ff;
            wr_data.prime    = def_prime_ff;
            wr_data.elapsed  = found_ff ? carry_el_ff : '0;
            wr_data.done     = found_ff ? carry_done_ff : 1'b0;
         end
         default: ;
      endcase

      // stall a step whose event cannot be placed
      step_go = !emit_req || !held_valid_ff || out_free;
      wr_en   = wr_en && step_go;
      fire    = emit_req && step_go;

      if (step_go && !last_idx &&
          (state_ff == prs_pkg::ST_START || state_ff == prs_pkg::ST_TICK_B ||
           state_ff == prs_pkg::ST_DEF_SCAN)) begin
         idx_in = idx_ff + prs_pkg::IDX_BITS'(1);
      end

      // held event and output register
      held_valid_in  = held_valid_ff;
      held_client_in = held_client_ff;
      held_phase_in  = held_phase_ff;
      out_load       = 1'b0;
      out_last_sel   = 1'b0;
      if (fire) begin
         held_valid_in  = 1'b1;
         held_client_in = emit_client;
         held_phase_in  = emit_phase;
         out_load       = held_valid_ff;
      end else if (state_ff == prs_pkg::ST_FLUSH && held_valid_ff && out_free) begin
         held_valid_in = 1'b0;
         out_load      = 1'b1;
         out_last_sel  = 1'b1;
      end

      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_client_in = out_client_ff;
      out_phase_in  = out_phase_ff;
      out_last_in   = out_last_ff;
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_client_in = held_client_ff;
         out_phase_in  = held_phase_ff;
         out_last_in   = out_last_sel;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prs_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  prs_pkg::CMD_TICK:   if (running_ff) state_in = prs_pkg::ST_TICK_A;
                  prs_pkg::CMD_DEFINE: if (slot_ok) state_in = prs_pkg::ST_DEF_SCAN;
                  prs_pkg::CMD_START:  state_in = prs_pkg::ST_START;
                  default: ;
               endcase
            end
         end
         prs_pkg::ST_START:     if (step_go && last_idx) state_in = prs_pkg::ST_FLUSH;
         prs_pkg::ST_TICK_A:    if (step_go) state_in = prs_pkg::ST_TICK_B;
         prs_pkg::ST_TICK_B: begin
            if (step_go) state_in = last_idx ? prs_pkg::ST_FLUSH : prs_pkg::ST_TICK_A;
         end
         prs_pkg::ST_DEF_SCAN:  if (match || last_idx) state_in = prs_pkg::ST_DEF_WRITE;
         prs_pkg::ST_DEF_WRITE: state_in = prs_pkg::ST_IDLE;
         prs_pkg::ST_FLUSH:     if (!held_valid_ff || out_free) state_in = prs_pkg::ST_IDLE;
         default:               state_in = prs_pkg::ST_IDLE;
      endcase
   end

   // control registers and slot table
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= prs_pkg::ST_IDLE;
         idx_ff        <= '0;
         running_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < prs_pkg::NUM_SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         running_ff    <= running_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
         if (wr_en) begin
            slot_ff[wr_idx] <= wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tgt_ff          <= tgt_in;
      def_client_ff   <= def_client_in;
      def_interval_ff <= def_interval_in;
      def_offset_ff   <= def_offset_in;
      def_prime_ff    <= def_prime_in;
      found_ff        <= found_in;
      carry_el_ff     <= carry_el_in;
      carry_done_ff   <= carry_done_in;
      held_client_ff  <= held_client_in;
      held_phase_ff   <= held_phase_in;
      out_client_ff   <= out_client_in;
      out_phase_ff    <= out_phase_in;
      out_last_ff     <= out_last_in;
   end

   // channel ports
   assign req_ch.ready        = (state_ff == prs_pkg::ST_IDLE);
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.event_client = out_client_ff;
   assign rsp_ch.event_phase  = out_phase_ff;
   assign rsp_ch.last_event   = out_last_ff;

endmodule
